### rtl/lcdseq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcdseq_pkg: shared types, codes and microcode for the LCD write sequencer
// Control word layout, request codes, entry points and the program table.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

	// field widths
	localparam int unsigned NUM_W  = 32;
	localparam int unsigned PC_W   = 6;
	localparam int unsigned HOLD_W = 6;
	localparam int unsigned MAX_DIGITS_DEF = 10;

	// request codes
	localparam logic [1:0] REQ_INIT = 2'd0;
	localparam logic [1:0] REQ_CMD  = 2'd1;
	localparam logic [1:0] REQ_DATA = 2'd2;
	localparam logic [1:0] REQ_NUM  = 2'd3;

	// program entry points
	localparam logic [PC_W-1:0] ENTRY_INIT = 6'd0;
	localparam logic [PC_W-1:0] ENTRY_BYTE = 6'd25;
	localparam logic [PC_W-1:0] ENTRY_DIV  = 6'd29;
	localparam logic [PC_W-1:0] ENTRY_POP  = 6'd30;

	// ascii '0' high nibble
	localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

	typedef enum logic [1:0] {
		OP_EMIT = 2'd0,
		OP_DIV  = 2'd1,
		OP_POP  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		NIB_CONST = 2'd0,
		NIB_HI    = 2'd1,
		NIB_LO    = 2'd2
	} nib_sel_t;

	typedef enum logic [1:0] {
		LAST_NO    = 2'd0,
		LAST_YES   = 2'd1,
		LAST_EMPTY = 2'd2
	} last_sel_t;

	typedef enum logic [1:0] {
		JMP_NEXT     = 2'd0,
		JMP_END      = 2'd1,
		JMP_DIV_MORE = 2'd2,
		JMP_STACK    = 2'd3
	} jmp_t;

	typedef struct packed {
		op_t               op;
		nib_sel_t          nib_sel;
		logic [3:0]        nib;
		logic              rs_req;
		logic              en;
		logic [HOLD_W-1:0] hold;
		last_sel_t         last_sel;
		jmp_t              jmp;
		logic [PC_W-1:0]   target;
	} ucode_t;

	// build one pin-state step
	function automatic ucode_t uc_emit(input nib_sel_t sel, input logic [3:0] nib,
			input logic rs_req, input logic en, input logic [HOLD_W-1:0] hold,
			input last_sel_t last_sel, input jmp_t jmp, input logic [PC_W-1:0] target);
		ucode_t w;
		w.op       = OP_EMIT;
		w.nib_sel  = sel;
		w.nib      = nib;
		w.rs_req   = rs_req;
		w.en       = en;
		w.hold     = hold;
		w.last_sel = last_sel;
		w.jmp      = jmp;
		w.target   = target;
		return w;
	endfunction

	// build a non-emitting step
	function automatic ucode_t uc_ctl(input op_t op, input jmp_t jmp,
			input logic [PC_W-1:0] target);
		ucode_t w;
		w          = '0;
		w.op       = op;
		w.nib_sel  = NIB_CONST;
		w.last_sel = LAST_NO;
		w.jmp      = jmp;
		w.target   = target;
		return w;
	endfunction

	// constant nibble, command register, plain step
	function automatic ucode_t uc_c(input logic [3:0] nib, input logic en,
			input logic [HOLD_W-1:0] hold);
		return uc_emit(NIB_CONST, nib, 1'b0, en, hold, LAST_NO, JMP_NEXT, '0);
	endfunction

	// program rom
	function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
		ucode_t w;
		case (pc)
			// power-up wait
			6'd0:  w = uc_c(4'h0, 1'b0, 6'd50);
			// wake-up nibbles 3,3,3 then 2
			6'd1:  w = uc_c(4'h3, 1'b1, 6'd2);
			6'd2:  w = uc_c(4'h3, 1'b0, 6'd22);
			6'd3:  w = uc_c(4'h3, 1'b1, 6'd2);
			6'd4:  w = uc_c(4'h3, 1'b0, 6'd22);
			6'd5:  w = uc_c(4'h3, 1'b1, 6'd2);
			6'd6:  w = uc_c(4'h3, 1'b0, 6'd22);
			6'd7:  w = uc_c(4'h2, 1'b1, 6'd2);
			6'd8:  w = uc_c(4'h2, 1'b0, 6'd22);
			// function set 0x28
			6'd9:  w = uc_c(4'h2, 1'b1, 6'd2);
			6'd10: w = uc_c(4'h2, 1'b0, 6'd2);
			6'd11: w = uc_c(4'h8, 1'b1, 6'd2);
			6'd12: w = uc_c(4'h8, 1'b0, 6'd7);
			// display on 0x0C
			6'd13: w = uc_c(4'h0, 1'b1, 6'd2);
			6'd14: w = uc_c(4'h0, 1'b0, 6'd2);
			6'd15: w = uc_c(4'hC, 1'b1, 6'd2);
			6'd16: w = uc_c(4'hC, 1'b0, 6'd7);
			// entry mode 0x06
			6'd17: w = uc_c(4'h0, 1'b1, 6'd2);
			6'd18: w = uc_c(4'h0, 1'b0, 6'd2);
			6'd19: w = uc_c(4'h6, 1'b1, 6'd2);
			6'd20: w = uc_c(4'h6, 1'b0, 6'd7);
			// clear 0x01 with long settle
			6'd21: w = uc_c(4'h0, 1'b1, 6'd2);
			6'd22: w = uc_c(4'h0, 1'b0, 6'd2);
			6'd23: w = uc_c(4'h1, 1'b1, 6'd2);
			6'd24: w = uc_emit(NIB_CONST, 4'h1, 1'b0, 1'b0, 6'd27, LAST_YES, JMP_END, '0);
			// single byte from request
			6'd25: w = uc_emit(NIB_HI, 4'h0, 1'b1, 1'b1, 6'd2, LAST_NO, JMP_NEXT, '0);
			6'd26: w = uc_emit(NIB_HI, 4'h0, 1'b1, 1'b0, 6'd2, LAST_NO, JMP_NEXT, '0);
			6'd27: w = uc_emit(NIB_LO, 4'h0, 1'b1, 1'b1, 6'd2, LAST_NO, JMP_NEXT, '0);
			6'd28: w = uc_emit(NIB_LO, 4'h0, 1'b1, 1'b0, 6'd7, LAST_YES, JMP_END, '0);
			// number: split into digits, then print from the stack
			6'd29: w = uc_ctl(OP_DIV, JMP_DIV_MORE, ENTRY_DIV);
			6'd30: w = uc_ctl(OP_POP, JMP_NEXT, '0);
			6'd31: w = uc_emit(NIB_HI, 4'h0, 1'b1, 1'b1, 6'd2, LAST_NO, JMP_NEXT, '0);
			6'd32: w = uc_emit(NIB_HI, 4'h0, 1'b1, 1'b0, 6'd2, LAST_NO, JMP_NEXT, '0);
			6'd33: w = uc_emit(NIB_LO, 4'h0, 1'b1, 1'b1, 6'd2, LAST_NO, JMP_NEXT, '0);
			6'd34: w = uc_emit(NIB_LO, 4'h0, 1'b1, 1'b0, 6'd7, LAST_EMPTY, JMP_STACK,
				ENTRY_POP);
			default: w = uc_ctl(OP_POP, JMP_END, '0);
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

### rtl/lcdseq_div10.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcdseq_div10: divide by ten by reciprocal multiplication
// The quotient is registered on load, then the remainder from it while busy; done pulses for one cycle.
// ----------------------------------------------------------------------------
module lcdseq_div10
	import lcdseq_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             go,
	input  wire logic [NUM_W-1:0] dividend,
	output logic                  done,
	output logic [NUM_W-1:0]      quot,
	output logic [3:0]            rem
);

	// floor(x / 10) == (x * 0xCCCCCCCD) >> 35 for every 32-bit x
	localparam int unsigned PROD_W = 2 * NUM_W;
	localparam int unsigned SHIFT  = 35;
	localparam logic [NUM_W-1:0] RECIP = 32'hCCCC_CCCD;

	logic              busy_q;
	logic              done_q;
	logic [NUM_W-1:0]  quot_q;
	logic [3:0]        lo_q;
	logic [3:0]        rem_q;
	logic [PROD_W-1:0] prod;
	logic              load;

	// reciprocal product of the incoming dividend
	assign prod = PROD_W'(dividend) * PROD_W'(RECIP);
	assign load = go && !busy_q && !done_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else if (load) begin
				busy_q <= 1'b1;
			end
		end
	end

	// datapath: remainder from the low bits, x - 10q taken mod 16
	always_ff @(posedge clk) begin
		if (load) begin
			quot_q <= NUM_W'(prod >> SHIFT);
			lo_q   <= dividend[3:0];
		end
		if (busy_q) begin
			rem_q <= lo_q - ({quot_q[0], 3'b000} + {quot_q[2:0], 1'b0});
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule
`default_nettype wire

### rtl/char_lcd_nibble_write_sequencer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Request path: start is latched into the step counter, then the first step's pin state
// is registered on the outputs; init gives 25 beats, a byte request 4 beats.
// Number print: each digit is split off by a divide by ten, then sent by a pop step
// and four beats; at most ten digits with the default MAX_DIGITS.
// One request at a time; busy stays high until the final step is issued.
// The receiver takes every beat; reset clears the sequencer and the output strobe.
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer_top: microcoded 4-bit LCD write sequencer
// A step counter walks a program rom; each step emits one timed pin state,
// runs a digit division, or pops a digit from the digit stack.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer_top
	import lcdseq_pkg::*;
#(
	parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
)(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [1:0]        req_type,
	input  wire logic [7:0]        byte_value,
	input  wire logic [NUM_W-1:0]  number,
	output logic                   valid,
	output logic [3:0]             data_nibble,
	output logic                   reg_select,
	output logic                   enable,
	output logic [HOLD_W-1:0]      hold_ms,
	output logic                   last
);

	localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);

	logic              run_q;
	logic [PC_W-1:0]   pc_q;
	logic [PC_W-1:0]   pc_nxt;
	logic              finish;
	logic              accept;
	logic [PC_W-1:0]   entry;
	ucode_t            cw;
	logic              rs_q;
	logic [7:0]        byte_q;
	logic [NUM_W-1:0]  value_q;
	logic [3:0]        digit_q [MAX_DIGITS];
	logic [CNT_W-1:0]  dcnt_q;
	logic              div_go;
	logic              div_done;
	logic [NUM_W-1:0]  div_quot;
	logic [3:0]        div_rem;
	logic              do_emit;
	logic              do_pop;
	logic              do_push;
	logic [3:0]        nib;
	logic              valid_q;
	logic [3:0]        nib_q;
	logic              rs_out_q;
	logic              en_q;
	logic [HOLD_W-1:0] hold_q;
	logic              last_q;

	assign accept = start && !run_q;
	assign cw     = ucode(pc_q);

	// entry point per request type
	always_comb begin
		case (req_type)
			REQ_INIT:          entry = ENTRY_INIT;
			REQ_CMD, REQ_DATA: entry = ENTRY_BYTE;
			default:           entry = ENTRY_DIV;
		endcase
	end

	// step sequencing
	always_comb begin
		pc_nxt = pc_q + 1'b1;
		finish = 1'b0;
		case (cw.jmp)
			JMP_NEXT: pc_nxt = pc_q + 1'b1;
			JMP_END:  finish = 1'b1;
			JMP_DIV_MORE: begin
				if (!div_done) begin
					pc_nxt = pc_q;
				end else if (div_quot != '0 && dcnt_q < CNT_W'(MAX_DIGITS - 1)) begin
					pc_nxt = cw.target;
				end
			end
			JMP_STACK: begin
				if (dcnt_q != '0) begin
					pc_nxt = cw.target;
				end else begin
					finish = 1'b1;
				end
			end
			default: finish = 1'b1;
		endcase
	end

	assign do_emit = run_q && (cw.op == OP_EMIT);
	assign do_pop  = run_q && (cw.op == OP_POP);
	assign do_push = run_q && (cw.op == OP_DIV) && div_done;
	assign div_go  = run_q && (cw.op == OP_DIV) && !div_done;

	// sequencer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			pc_q  <= '0;
		end else if (accept) begin
			run_q <= 1'b1;
			pc_q  <= entry;
		end else if (run_q) begin
			if (finish) begin
				run_q <= 1'b0;
			end
			pc_q <= pc_nxt;
		end
	end

	// request latch and working value
	always_ff @(posedge clk) begin
		if (accept) begin
			rs_q    <= req_type inside {REQ_DATA, REQ_NUM};
			byte_q  <= byte_value;
			value_q <= number;
		end else begin
			if (do_push) begin
				value_q <= div_quot;
			end
			if (do_pop) begin
				byte_q <= {ASCII_DIGIT_HI, digit_q[0]};
			end
		end
	end

	// digit stack: push and pop at the head
	always_ff @(posedge clk) begin
		if (do_push) begin
			digit_q[0] <= div_rem;
			for (int i = 1; i < MAX_DIGITS; i++) begin
				digit_q[i] <= digit_q[i-1];
			end
		end else if (do_pop) begin
			for (int i = 0; i < MAX_DIGITS - 1; i++) begin
				digit_q[i] <= digit_q[i+1];
			end
		end
	end

	// digit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (accept) begin
			dcnt_q <= '0;
		end else if (do_push) begin
			dcnt_q <= dcnt_q + 1'b1;
		end else if (do_pop) begin
			dcnt_q <= dcnt_q - 1'b1;
		end
	end

	lcdseq_div10 u_div10 (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (value_q),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// nibble source select
	always_comb begin
		case (cw.nib_sel)
			NIB_HI:  nib = byte_q[7:4];
			NIB_LO:  nib = byte_q[3:0];
			default: nib = cw.nib;
		endcase
	end

	// output strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= do_emit;
		end
	end

	// output beat register
	always_ff @(posedge clk) begin
		if (do_emit) begin
			nib_q    <= nib;
			rs_out_q <= cw.rs_req && rs_q;
			en_q     <= cw.en;
			hold_q   <= cw.hold;
			last_q   <= (cw.last_sel == LAST_YES) ||
				((cw.last_sel == LAST_EMPTY) && (dcnt_q == '0));
		end
	end

	assign busy        = run_q;
	assign valid       = valid_q;
	assign data_nibble = nib_q;
	assign reg_select  = rs_out_q;
	assign enable      = en_q;
	assign hold_ms     = hold_q;
	assign last        = last_q;

	// a beat only follows a running step
	a_beat_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> $past(run_q))
		else $error("beat without running sequence");

	// divider finishes only while a divide step is active
	a_div_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (run_q && cw.op == OP_DIV))
		else $error("divider result outside divide step");

	// digit stack never overfills
	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dcnt_q <= CNT_W'(MAX_DIGITS))
		else $error("digit stack overflow");

	// a pop always finds a digit
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop |-> (dcnt_q != '0))
		else $error("pop from empty digit stack");

	// the final beat of a request ends the run
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && last_q) |-> (!run_q && $past(finish)))
		else $error("last beat while sequence continues");

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the character-LCD nibble write sequencer
// Sends init, command, data and number requests in random bursts, predicts the
// pin-state beats each one should produce and checks every beat in order.
// ----------------------------------------------------------------------------
module tb;
	import lcdseq_pkg::*;

	localparam int unsigned DIGITS_MAX = 10;

	// one lcd request
	typedef struct {
		logic [1:0]       kind;
		logic [7:0]       bval;
		logic [NUM_W-1:0] num;
	} lcd_req_t;

	// one timed pin state
	typedef struct {
		logic [3:0]        nib;
		logic              rs;
		logic              en;
		logic [HOLD_W-1:0] hold;
		logic              fin;
	} lcd_pin_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] req_type = REQ_INIT;
	logic [7:0] byte_value = 8'h00;
	logic [NUM_W-1:0] number = '0;
	logic busy;
	logic valid;
	logic [3:0] data_nibble;
	logic reg_select;
	logic enable;
	logic [HOLD_W-1:0] hold_ms;
	logic last;

	lcd_req_t req_backlog[$];
	lcd_pin_t pins_due[$];
	int n_issued = 0;
	int n_taken = 0;
	int n_fail = 0;
	int burst_left = 0;
	int gap_left = 0;

	char_lcd_nibble_write_sequencer_top #(
		.MAX_DIGITS(DIGITS_MAX)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.byte_value(byte_value),
		.number(number),
		.valid(valid),
		.data_nibble(data_nibble),
		.reg_select(reg_select),
		.enable(enable),
		.hold_ms(hold_ms),
		.last(last)
	);

	always #2 clk = ~clk;

	// ---------------- predictor ----------------

	task automatic emit_pin(input logic [3:0] nib, input logic rs, input logic en,
			input int unsigned hold, input logic fin);
		lcd_pin_t p;
		p.nib  = nib;
		p.rs   = rs;
		p.en   = en;
		p.hold = hold[HOLD_W-1:0];
		p.fin  = fin;
		pins_due.push_back(p);
	endtask

	// enable high 2 ms, then enable low 2 ms plus settle
	task automatic emit_nibble(input logic [3:0] nib, input logic rs,
			input int unsigned settle, input logic fin);
		emit_pin(nib, rs, 1'b1, 2, 1'b0);
		emit_pin(nib, rs, 1'b0, 2 + settle, fin);
	endtask

	task automatic emit_byte(input logic [7:0] b, input logic rs,
			input int unsigned settle, input logic fin);
		emit_nibble(b[7:4], rs, 0, 1'b0);
		emit_nibble(b[3:0], rs, 5 + settle, fin);
	endtask

	task automatic plan_request(input lcd_req_t r);
		logic [NUM_W-1:0] v;
		logic [3:0] digit[DIGITS_MAX];
		int nd;
		case (r.kind)
			REQ_INIT: begin
				emit_pin(4'h0, 1'b0, 1'b0, 50, 1'b0);
				emit_nibble(4'h3, 1'b0, 20, 1'b0);
				emit_nibble(4'h3, 1'b0, 20, 1'b0);
				emit_nibble(4'h3, 1'b0, 20, 1'b0);
				emit_nibble(4'h2, 1'b0, 20, 1'b0);
				emit_byte(8'h28, 1'b0, 0, 1'b0);
				emit_byte(8'h0C, 1'b0, 0, 1'b0);
				emit_byte(8'h06, 1'b0, 0, 1'b0);
				emit_byte(8'h01, 1'b0, 20, 1'b1);
			end
			REQ_CMD: emit_byte(r.bval, 1'b0, 0, 1'b1);
			REQ_DATA: emit_byte(r.bval, 1'b1, 0, 1'b1);
			default: begin
				// decimal digits, low first; zero prints one '0'
				v = r.num;
				nd = 0;
				if (v == '0) begin
					digit[0] = 4'd0;
					nd = 1;
				end
				while (v != '0 && nd < DIGITS_MAX) begin
					digit[nd] = 4'(v % 10);
					v = v / 10;
					nd++;
				end
				for (int k = nd - 1; k >= 0; k--)
					emit_byte({4'h3, digit[k]}, 1'b1, 0, k == 0);
			end
		endcase
	endtask

	// ---------------- checking ----------------

	task automatic note_fail(input string msg);
		n_fail++;
		if (n_fail <= 10)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// sample beats and accepted requests at the rising edge
	always @(posedge clk) begin
		lcd_pin_t want;
		lcd_req_t got_req;
		if (arst_n) begin
			if (valid) begin
				if (pins_due.size() == 0) begin
					note_fail($sformatf("unexpected beat nib=%h rs=%b en=%b hold=%0d last=%b",
						data_nibble, reg_select, enable, hold_ms, last));
				end else begin
					want = pins_due.pop_front();
					if (data_nibble !== want.nib || reg_select !== want.rs ||
							enable !== want.en || hold_ms !== want.hold ||
							last !== want.fin)
						note_fail($sformatf({"exp nib=%h rs=%b en=%b hold=%0d last=%b, ",
							"got nib=%h rs=%b en=%b hold=%0d last=%b"},
							want.nib, want.rs, want.en, want.hold, want.fin,
							data_nibble, reg_select, enable, hold_ms, last));
				end
			end
			if (start && !busy) begin
				got_req.kind = req_type;
				got_req.bval = byte_value;
				got_req.num  = number;
				plan_request(got_req);
				n_taken <= n_taken + 1;
			end
		end
	end

	// ---------------- driver ----------------

	// new request at the falling edge, in bursts with random gaps
	always @(negedge clk) begin
		lcd_req_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || n_taken == n_issued) begin
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (req_backlog.size() > 0) begin
				nxt = req_backlog.pop_front();
				start      <= 1'b1;
				req_type   <= nxt.kind;
				byte_value <= nxt.bval;
				number     <= nxt.num;
				n_issued++;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 8);
					case ($urandom_range(0, 3))
						0: gap_left = 0;
						1: gap_left = $urandom_range(1, 8);
						2: gap_left = $urandom_range(9, 60);
						default: gap_left = $urandom_range(61, 450);
					endcase
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ---------------- stimulus ----------------

	task automatic queue_req(input logic [1:0] kind, input logic [7:0] bval,
			input logic [NUM_W-1:0] num);
		lcd_req_t r;
		r.kind = kind;
		r.bval = bval;
		r.num  = num;
		req_backlog.push_back(r);
	endtask

	initial begin
		logic [1:0] kind;
		logic [NUM_W-1:0] num;
		// directed: extremes, every request kind, zero and widest numbers
		queue_req(REQ_INIT, 8'hFF, 32'hFFFF_FFFF);
		queue_req(REQ_CMD, 8'h00, 32'hFFFF_FFFF);
		queue_req(REQ_CMD, 8'hFF, '0);
		queue_req(REQ_CMD, 8'h5A, 32'h1234_5678);
		queue_req(REQ_DATA, 8'h00, 32'hFFFF_FFFF);
		queue_req(REQ_DATA, 8'hFF, '0);
		queue_req(REQ_DATA, 8'hA5, 32'hDEAD_BEEF);
		queue_req(REQ_NUM, 8'hFF, 32'd0);
		queue_req(REQ_NUM, 8'h00, 32'd9);
		queue_req(REQ_NUM, 8'h00, 32'd10);
		queue_req(REQ_NUM, 8'hFF, 32'd99);
		queue_req(REQ_NUM, 8'h00, 32'd100);
		queue_req(REQ_NUM, 8'h00, 32'd999_999_999);
		queue_req(REQ_NUM, 8'h00, 32'd1_000_000_000);
		queue_req(REQ_NUM, 8'h00, 32'd4_000_000_000);
		queue_req(REQ_NUM, 8'hFF, 32'hFFFF_FFFF);
		queue_req(REQ_NUM, 8'h00, 32'h8000_0000);
		queue_req(REQ_INIT, 8'h00, '0);
		queue_req(REQ_DATA, 8'h30, '0);

		// random: ignored fields random too, numbers of every length
		for (int i = 0; i < 91; i++) begin
			kind = 2'($urandom_range(0, 3));
			if (kind == REQ_INIT && $urandom_range(0, 2) != 0)
				kind = REQ_NUM;
			if ($urandom_range(0, 3) == 0)
				num = $urandom;
			else
				num = $urandom >> $urandom_range(0, 31);
			queue_req(kind, 8'($urandom_range(0, 255)), num);
		end

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// let everything drain, then a short settle
		while (req_backlog.size() > 0 || start || pins_due.size() > 0 || busy)
			@(posedge clk);
		repeat (64) @(posedge clk);
		if (valid || pins_due.size() > 0)
			note_fail("beats left over at end of run");

		if (n_fail == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

### filelist.f
rtl/lcdseq_pkg.sv
rtl/lcdseq_div10.sv
rtl/char_lcd_nibble_write_sequencer_top.sv
tb/tb.sv
